// ===== rtl/btfe_pkg.sv =====
// Shared types and constants for the biphase track frame encoder.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none

package btfe_pkg;

    // Field widths.
    localparam int unsigned DUR_W      = 15;
    localparam int unsigned RUN_W      = 4;
    localparam int unsigned CELL_IDX_W = 3;

    // Defaults for the top-level parameters.
    localparam int unsigned STUFF_RUN_DEF   = 8;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Reset value of the half-cell duration register.
    localparam logic [DUR_W-1:0] HALF_CELL_RESET = 15'd50;

    // Index of the final cell of each command.
    localparam logic [CELL_IDX_W-1:0] SYNC_LAST_IDX  = 3'd4;
    localparam logic [CELL_IDX_W-1:0] STUFF_LAST_IDX = 3'd1;
    localparam logic [CELL_IDX_W-1:0] SINGLE_IDX     = 3'd0;

    // Input item on the s_ channel.
    typedef struct packed {
        logic mode;
        logic bit_value;
    } in_item_t;

    // One bit cell on the m_ channel.
    typedef struct packed {
        logic             first_level;
        logic             second_level;
        logic [DUR_W-1:0] half_duration;
        logic             last_cell;
    } out_cell_t;

    // Classified work for the cell generator.
    typedef enum logic [1:0] {
        CMD_SYNC  = 2'd0,
        CMD_ZERO  = 2'd1,
        CMD_ONE   = 2'd2,
        CMD_STUFF = 2'd3
    } cmd_kind_t;

    // A command carries its kind and the line level before it.
    typedef struct packed {
        cmd_kind_t kind;
        logic      level;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/btfe_front.sv =====
// Front end: accepts input transactions, tracks line level and the ones run,
// and issues one command per item. Depends on btfe_pkg.
`default_nettype none

module btfe_front #(
    parameter int unsigned STUFF_RUN = btfe_pkg::STUFF_RUN_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire btfe_pkg::in_item_t s_data,
    input  wire logic              q_full,
    output logic                   q_push,
    output btfe_pkg::cmd_t         q_cmd
);

    localparam logic [btfe_pkg::RUN_W-1:0] STUFF_RUN_C = btfe_pkg::RUN_W'(STUFF_RUN);

    logic                         line_level_reg, line_level_next;
    logic [btfe_pkg::RUN_W-1:0]   ones_run_reg, ones_run_next;
    logic [btfe_pkg::RUN_W-1:0]   run_inc;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;
    assign run_inc = ones_run_reg + 1'b1;

    // Classify the item and work out the state it leaves behind.
    always_comb begin
        q_cmd.level     = line_level_reg;
        q_cmd.kind      = btfe_pkg::CMD_SYNC;
        line_level_next = line_level_reg;
        ones_run_next   = '0;
        if (!s_data.mode) begin
            q_cmd.kind = btfe_pkg::CMD_SYNC;
        end else if (!s_data.bit_value) begin
            q_cmd.kind      = btfe_pkg::CMD_ZERO;
            line_level_next = !line_level_reg;
        end else if (run_inc >= STUFF_RUN_C) begin
            q_cmd.kind      = btfe_pkg::CMD_STUFF;
            line_level_next = !line_level_reg;
        end else begin
            q_cmd.kind    = btfe_pkg::CMD_ONE;
            ones_run_next = run_inc;
        end
    end

    // State advances on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_level_reg <= 1'b0;
            ones_run_reg   <= '0;
        end else if (q_push) begin
            line_level_reg <= line_level_next;
            ones_run_reg   <= ones_run_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/btfe_queue.sv =====
// Small command queue between the front end and the cell generator.
// Depends on btfe_pkg for the command type.
`default_nettype none

module btfe_queue #(
    parameter int unsigned DEPTH = btfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire btfe_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output logic                full,
    output logic                empty,
    output btfe_pkg::cmd_t      head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

    btfe_pkg::cmd_t     mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == DEPTH_C);
    assign empty    = (count_reg == '0);
    assign head_cmd = mem[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/btfe_back.sv =====
// Cell generator: expands each queued command into bit cells and holds
// them in the output register. Depends on btfe_pkg.
`default_nettype none

module btfe_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_empty,
    input  wire btfe_pkg::cmd_t              head_cmd,
    output logic                             q_pop,
    input  wire logic [btfe_pkg::DUR_W-1:0]  half_cell_ticks,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output btfe_pkg::out_cell_t              m_data
);

    logic [btfe_pkg::CELL_IDX_W-1:0] idx_reg, idx_next;
    logic                            m_valid_reg, m_valid_next;
    btfe_pkg::out_cell_t             m_data_reg;
    btfe_pkg::out_cell_t             cur_cell;
    logic [btfe_pkg::CELL_IDX_W-1:0] last_idx;
    logic                            lv, nlv;
    logic                            advance, load;

    assign lv  = head_cmd.level;
    assign nlv = !head_cmd.level;

    // Levels of the current cell from the command and the cell index.
    always_comb begin
        cur_cell.first_level   = nlv;
        cur_cell.second_level  = nlv;
        cur_cell.half_duration = half_cell_ticks;
        last_idx               = btfe_pkg::SINGLE_IDX;
        unique case (head_cmd.kind)
            btfe_pkg::CMD_SYNC: begin
                last_idx = btfe_pkg::SYNC_LAST_IDX;
                case (idx_reg)
                    3'd0: begin
                        cur_cell.first_level  = nlv;
                        cur_cell.second_level = nlv;
                    end
                    3'd1, 3'd3: begin
                        cur_cell.first_level  = lv;
                        cur_cell.second_level = nlv;
                    end
                    3'd2: begin
                        cur_cell.first_level  = nlv;
                        cur_cell.second_level = lv;
                    end
                    default: begin
                        cur_cell.first_level  = lv;
                        cur_cell.second_level = lv;
                    end
                endcase
            end
            btfe_pkg::CMD_ZERO: begin
                last_idx = btfe_pkg::SINGLE_IDX;
            end
            btfe_pkg::CMD_ONE: begin
                last_idx              = btfe_pkg::SINGLE_IDX;
                cur_cell.second_level = lv;
            end
            btfe_pkg::CMD_STUFF: begin
                // The data one first, then the stuffed zero.
                last_idx              = btfe_pkg::STUFF_LAST_IDX;
                cur_cell.second_level = (idx_reg == '0) ? lv : nlv;
            end
            default: begin
                last_idx = btfe_pkg::SINGLE_IDX;
            end
        endcase
        cur_cell.last_cell = (idx_reg == last_idx);
    end

    // One cell per cycle whenever the output register is free or draining and the queue holds a command.
    assign advance = !m_valid_reg || m_ready;
    assign load    = advance && !q_empty;
    assign q_pop   = load && cur_cell.last_cell;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = !q_empty;
        end
        if (load) begin
            idx_next = cur_cell.last_cell ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= cur_cell;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/biphase_track_frame_encoder.sv =====
// Top level of the biphase track frame encoder with bit stuffing.
// Instantiates btfe_front, btfe_queue and btfe_back; depends on btfe_pkg.
//
// Each input transaction is a frame start (mode 0) or one data bit (mode 1)
// and yields five, one or two bit cells on the m_ channel, one cell per
// transaction there; the final cell of an item has last_cell set. The front
// end classifies an item in the cycle it is accepted and takes a new one
// every cycle while the command queue (QUEUE_DEPTH entries) has room. The
// cell generator behind the queue emits one cell per clock through its
// output register while m_ready does not stall it, so the sustained rate is
// one cell per cycle. When the path is empty, an accepted item passes
// through the command queue and then the output register before its first
// cell is presented. half_cell_ticks is written through cfg_we/cfg_wdata,
// resets to 50, and should be changed only while no cells are pending.
`default_nettype none

module biphase_track_frame_encoder #(
    parameter int unsigned STUFF_RUN   = btfe_pkg::STUFF_RUN_DEF,
    parameter int unsigned QUEUE_DEPTH = btfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire btfe_pkg::in_item_t          s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output btfe_pkg::out_cell_t              m_data,
    input  wire logic                        cfg_we,
    input  wire logic [btfe_pkg::DUR_W-1:0]  cfg_wdata
);

    logic [btfe_pkg::DUR_W-1:0] half_cell_ticks_reg;
    logic                       q_full, q_empty, q_push, q_pop;
    btfe_pkg::cmd_t             push_cmd, head_cmd;

    // Half-cell duration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_cell_ticks_reg <= btfe_pkg::HALF_CELL_RESET;
        end else if (cfg_we) begin
            half_cell_ticks_reg <= cfg_wdata;
        end
    end

    btfe_front #(
        .STUFF_RUN (STUFF_RUN)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    btfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    btfe_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .head_cmd        (head_cmd),
        .q_pop           (q_pop),
        .half_cell_ticks (half_cell_ticks_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule

`default_nettype wire
